### hdl/ldrs_pkg.sv
`timescale 1ns / 1ps
// Package for the LOOK disk request scheduler: field widths, parameter defaults,
// operation codes and the per-cell update mode. Depends on nothing else.
package ldrs_pkg;

  localparam int unsigned TrackW = 16;
  localparam int unsigned ArrW   = 32;
  localparam int unsigned IdW    = 16;

  localparam int unsigned DefQueueDepth = 64;
  localparam int unsigned DefTrackBits  = 16;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_INSERT,
    MODE_REMOVE
  } ldrs_mode_e;

endpackage

### hdl/ldrs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and result sides of the scheduler.
// Depends on ldrs_pkg for the field widths.
interface ldrs_req_if import ldrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [TrackW-1:0] req_track;
  logic [ArrW-1:0]   req_arrival;
  logic [IdW-1:0]    req_id;

  modport source (output valid, op, req_track, req_arrival, req_id, input ready);
  modport sink (input valid, op, req_track, req_arrival, req_id, output ready);
endinterface

interface ldrs_rsp_if import ldrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IdW-1:0]    served_id;
  logic [TrackW-1:0] served_track;
  logic [ArrW-1:0]   served_arrival;
  logic              empty_flag;
  logic              full_flag;

  modport source (output valid, served_id, served_track, served_arrival, empty_flag,
                  full_flag, input ready);
  modport sink (input valid, served_id, served_track, served_arrival, empty_flag,
                full_flag, output ready);
endinterface

### hdl/ldrs_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted request chain, with the two search carries that ripple
// toward slot zero. Depends on ldrs_pkg.
module ldrs_cell import ldrs_pkg::*; #(
  parameter int unsigned TRACK_BITS = DefTrackBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ldrs_mode_e            mode_i,
  input  logic [TRACK_BITS-1:0] new_track_i,
  input  logic [ArrW-1:0]       new_arrival_i,
  input  logic [IdW-1:0]        new_id_i,
  input  logic [TRACK_BITS-1:0] key_track_i,
  input  logic [TRACK_BITS-1:0] last_track_i,
  input  logic                  prev_valid_i,
  input  logic                  prev_gt_i,
  input  logic [TRACK_BITS-1:0] prev_track_i,
  input  logic [ArrW-1:0]       prev_arrival_i,
  input  logic [IdW-1:0]        prev_id_i,
  input  logic                  next_valid_i,
  input  logic [TRACK_BITS-1:0] next_track_i,
  input  logic [ArrW-1:0]       next_arrival_i,
  input  logic [IdW-1:0]        next_id_i,
  input  logic                  nxt_up_found_i,
  input  logic [TRACK_BITS-1:0] nxt_up_track_i,
  input  logic [ArrW-1:0]       nxt_up_arrival_i,
  input  logic [IdW-1:0]        nxt_up_id_i,
  input  logic                  nxt_dn_found_i,
  input  logic [TRACK_BITS-1:0] nxt_dn_track_i,
  input  logic [ArrW-1:0]       nxt_dn_arrival_i,
  input  logic [IdW-1:0]        nxt_dn_id_i,
  output logic                  valid_o,
  output logic                  gt_o,
  output logic [TRACK_BITS-1:0] track_o,
  output logic [ArrW-1:0]       arrival_o,
  output logic [IdW-1:0]        id_o,
  output logic                  up_found_o,
  output logic [TRACK_BITS-1:0] up_track_o,
  output logic [ArrW-1:0]       up_arrival_o,
  output logic [IdW-1:0]        up_id_o,
  output logic                  dn_found_o,
  output logic [TRACK_BITS-1:0] dn_track_o,
  output logic [ArrW-1:0]       dn_arrival_o,
  output logic [IdW-1:0]        dn_id_o
);

  logic                  valid_q, valid_d;
  logic [TRACK_BITS-1:0] track_q, track_d;
  logic [ArrW-1:0]       arrival_q, arrival_d;
  logic [IdW-1:0]        id_q, id_d;

  logic                  up_found_q, up_found_d;
  logic [TRACK_BITS-1:0] up_track_q, up_track_d;
  logic [ArrW-1:0]       up_arrival_q, up_arrival_d;
  logic [IdW-1:0]        up_id_q, up_id_d;
  logic                  dn_found_q, dn_found_d;
  logic [TRACK_BITS-1:0] dn_track_q, dn_track_d;
  logic [ArrW-1:0]       dn_arrival_q, dn_arrival_d;
  logic [IdW-1:0]        dn_id_q, dn_id_d;

  logic gt, ge, le, rm, dn_take;

  assign gt = !valid_q || (track_q > new_track_i) ||
              ((track_q == new_track_i) && (arrival_q >= new_arrival_i));
  assign ge = valid_q && (track_q >= last_track_i);
  assign le = valid_q && (track_q <= last_track_i);
  assign rm = valid_q && (track_q >= key_track_i);
  assign dn_take = le && (!nxt_dn_found_i || (track_q == nxt_dn_track_i));

  always_comb begin
    valid_d   = valid_q;
    track_d   = track_q;
    arrival_d = arrival_q;
    id_d      = id_q;
    unique case (mode_i)
      MODE_INSERT: begin
        if (gt) begin
          if (prev_gt_i) begin
            valid_d   = prev_valid_i;
            track_d   = prev_track_i;
            arrival_d = prev_arrival_i;
            id_d      = prev_id_i;
          end else begin
            valid_d   = 1'b1;
            track_d   = new_track_i;
            arrival_d = new_arrival_i;
            id_d      = new_id_i;
          end
        end
      end
      MODE_REMOVE: begin
        if (rm) begin
          valid_d   = next_valid_i;
          track_d   = next_track_i;
          arrival_d = next_arrival_i;
          id_d      = next_id_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (ge) begin
      up_found_d   = 1'b1;
      up_track_d   = track_q;
      up_arrival_d = arrival_q;
      up_id_d      = id_q;
    end else begin
      up_found_d   = nxt_up_found_i;
      up_track_d   = nxt_up_track_i;
      up_arrival_d = nxt_up_arrival_i;
      up_id_d      = nxt_up_id_i;
    end
    if (dn_take) begin
      dn_found_d   = 1'b1;
      dn_track_d   = track_q;
      dn_arrival_d = arrival_q;
      dn_id_d      = id_q;
    end else begin
      dn_found_d   = nxt_dn_found_i;
      dn_track_d   = nxt_dn_track_i;
      dn_arrival_d = nxt_dn_arrival_i;
      dn_id_d      = nxt_dn_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      up_found_q <= 1'b0;
      dn_found_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      up_found_q <= up_found_d;
      dn_found_q <= dn_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    track_q      <= track_d;
    arrival_q    <= arrival_d;
    id_q         <= id_d;
    up_track_q   <= up_track_d;
    up_arrival_q <= up_arrival_d;
    up_id_q      <= up_id_d;
    dn_track_q   <= dn_track_d;
    dn_arrival_q <= dn_arrival_d;
    dn_id_q      <= dn_id_d;
  end

  assign valid_o      = valid_q;
  assign gt_o         = gt;
  assign track_o      = track_q;
  assign arrival_o    = arrival_q;
  assign id_o         = id_q;
  assign up_found_o   = up_found_q;
  assign up_track_o   = up_track_q;
  assign up_arrival_o = up_arrival_q;
  assign up_id_o      = up_id_q;
  assign dn_found_o   = dn_found_q;
  assign dn_track_o   = dn_track_q;
  assign dn_arrival_o = dn_arrival_q;
  assign dn_id_o      = dn_id_q;

endmodule

### hdl/look_disk_request_scheduler.sv
`timescale 1ns / 1ps
// Top level of the LOOK disk request scheduler: sequencer, result register and the
// chain of ldrs_cell slots. Depends on ldrs_pkg, ldrs_if and ldrs_cell.
//
//   Channel  Direction  Handshake      Carries
//   req_i    in         valid / ready  op, req_track, req_arrival, req_id
//   rsp_o    out        valid / ready  served_id/track/arrival, empty_flag, full_flag
//
// On an add that finds room, the chain inserts in the transfer cycle.
// On a get the sequencer scans while the search carries ripple toward slot zero, then serves.
// A get on an empty table skips the scan and returns an empty result.
// Reset empties the table at once; there is no clearing pass.
// A result waits in the output register; a new item is taken meanwhile.
module look_disk_request_scheduler import ldrs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth,
  parameter int unsigned TRACK_BITS  = DefTrackBits
) (
  input logic    clk_i,
  input logic    rst_ni,
  ldrs_req_if.sink   req_i,
  ldrs_rsp_if.source rsp_o
);

  localparam int unsigned CntW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(QUEUE_DEPTH - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_SERVE  = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [TRACK_BITS-1:0] last_seek_q, last_seek_d;
  logic                  moving_up_q, moving_up_d;

  logic              res_empty_q, res_empty_d;
  logic              res_full_q, res_full_d;
  logic [IdW-1:0]    res_id_q, res_id_d;
  logic [TrackW-1:0] res_track_q, res_track_d;
  logic [ArrW-1:0]   res_arrival_q, res_arrival_d;

  logic              out_valid_q, out_valid_d;
  logic              out_empty_q, out_full_q;
  logic [IdW-1:0]    out_id_q;
  logic [TrackW-1:0] out_track_q;
  logic [ArrW-1:0]   out_arrival_q;
  logic              out_load;

  ldrs_mode_e            mode;
  logic [TRACK_BITS-1:0] new_track, key_track;
  logic                  accept, use_up;
  logic [TRACK_BITS-1:0] sel_track;
  logic [ArrW-1:0]       sel_arrival;
  logic [IdW-1:0]        sel_id;

  logic                  valid_w      [QUEUE_DEPTH];
  logic                  gt_w         [QUEUE_DEPTH];
  logic [TRACK_BITS-1:0] track_w      [QUEUE_DEPTH];
  logic [ArrW-1:0]       arrival_w    [QUEUE_DEPTH];
  logic [IdW-1:0]        id_w         [QUEUE_DEPTH];
  logic                  up_found_w   [QUEUE_DEPTH];
  logic [TRACK_BITS-1:0] up_track_w   [QUEUE_DEPTH];
  logic [ArrW-1:0]       up_arrival_w [QUEUE_DEPTH];
  logic [IdW-1:0]        up_id_w      [QUEUE_DEPTH];
  logic                  dn_found_w   [QUEUE_DEPTH];
  logic [TRACK_BITS-1:0] dn_track_w   [QUEUE_DEPTH];
  logic [ArrW-1:0]       dn_arrival_w [QUEUE_DEPTH];
  logic [IdW-1:0]        dn_id_w      [QUEUE_DEPTH];

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && (state_q == ST_IDLE);
  assign new_track   = TRACK_BITS'(req_i.req_track);

  assign use_up      = moving_up_q ? up_found_w[0] : !dn_found_w[0];
  assign sel_track   = use_up ? up_track_w[0] : dn_track_w[0];
  assign sel_arrival = use_up ? up_arrival_w[0] : dn_arrival_w[0];
  assign sel_id      = use_up ? up_id_w[0] : dn_id_w[0];
  assign key_track   = sel_track;

  assign out_load = (state_q == ST_RESULT) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    last_seek_d   = last_seek_q;
    moving_up_d   = moving_up_q;
    res_empty_d   = res_empty_q;
    res_full_d    = res_full_q;
    res_id_d      = res_id_q;
    res_track_d   = res_track_q;
    res_arrival_d = res_arrival_q;
    mode          = MODE_HOLD;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_empty_d   = 1'b0;
          res_full_d    = 1'b0;
          res_id_d      = '0;
          res_track_d   = '0;
          res_arrival_d = '0;
          cnt_d         = '0;
          if (req_i.op == OP_ADD) begin
            if (valid_w[QUEUE_DEPTH-1]) begin
              res_full_d = 1'b1;
            end else begin
              mode = MODE_INSERT;
            end
            state_d = ST_RESULT;
          end else if (!valid_w[0]) begin
            res_empty_d = 1'b1;
            state_d     = ST_RESULT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          state_d = ST_SERVE;
        end
      end
      ST_SERVE: begin
        mode          = MODE_REMOVE;
        res_id_d      = sel_id;
        res_track_d   = TrackW'(sel_track);
        res_arrival_d = sel_arrival;
        last_seek_d   = sel_track;
        moving_up_d   = use_up;
        state_d       = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_seek_q <= '0;
      moving_up_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_seek_q <= last_seek_d;
      moving_up_q <= moving_up_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_empty_q   <= res_empty_d;
    res_full_q    <= res_full_d;
    res_id_q      <= res_id_d;
    res_track_q   <= res_track_d;
    res_arrival_q <= res_arrival_d;
    if (out_load) begin
      out_empty_q   <= res_empty_q;
      out_full_q    <= res_full_q;
      out_id_q      <= res_id_q;
      out_track_q   <= res_track_q;
      out_arrival_q <= res_arrival_q;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.served_id      = out_id_q;
  assign rsp_o.served_track   = out_track_q;
  assign rsp_o.served_arrival = out_arrival_q;
  assign rsp_o.empty_flag     = out_empty_q;
  assign rsp_o.full_flag      = out_full_q;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                  prev_valid, prev_gt;
    logic [TRACK_BITS-1:0] prev_track;
    logic [ArrW-1:0]       prev_arrival;
    logic [IdW-1:0]        prev_id;
    logic                  next_valid;
    logic [TRACK_BITS-1:0] next_track;
    logic [ArrW-1:0]       next_arrival;
    logic [IdW-1:0]        next_id;
    logic                  nxt_up_found, nxt_dn_found;
    logic [TRACK_BITS-1:0] nxt_up_track, nxt_dn_track;
    logic [ArrW-1:0]       nxt_up_arrival, nxt_dn_arrival;
    logic [IdW-1:0]        nxt_up_id, nxt_dn_id;

    if (i == 0) begin : g_head
      assign prev_valid   = 1'b0;
      assign prev_gt      = 1'b0;
      assign prev_track   = '0;
      assign prev_arrival = '0;
      assign prev_id      = '0;
    end else begin : g_body
      assign prev_valid   = valid_w[i-1];
      assign prev_gt      = gt_w[i-1];
      assign prev_track   = track_w[i-1];
      assign prev_arrival = arrival_w[i-1];
      assign prev_id      = id_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_valid     = 1'b0;
      assign next_track     = '0;
      assign next_arrival   = '0;
      assign next_id        = '0;
      assign nxt_up_found   = 1'b0;
      assign nxt_up_track   = '0;
      assign nxt_up_arrival = '0;
      assign nxt_up_id      = '0;
      assign nxt_dn_found   = 1'b0;
      assign nxt_dn_track   = '0;
      assign nxt_dn_arrival = '0;
      assign nxt_dn_id      = '0;
    end else begin : g_link
      assign next_valid     = valid_w[i+1];
      assign next_track     = track_w[i+1];
      assign next_arrival   = arrival_w[i+1];
      assign next_id        = id_w[i+1];
      assign nxt_up_found   = up_found_w[i+1];
      assign nxt_up_track   = up_track_w[i+1];
      assign nxt_up_arrival = up_arrival_w[i+1];
      assign nxt_up_id      = up_id_w[i+1];
      assign nxt_dn_found   = dn_found_w[i+1];
      assign nxt_dn_track   = dn_track_w[i+1];
      assign nxt_dn_arrival = dn_arrival_w[i+1];
      assign nxt_dn_id      = dn_id_w[i+1];
    end

    ldrs_cell #(
      .TRACK_BITS(TRACK_BITS)
    ) u_cell (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .mode_i           (mode),
      .new_track_i      (new_track),
      .new_arrival_i    (req_i.req_arrival),
      .new_id_i         (req_i.req_id),
      .key_track_i      (key_track),
      .last_track_i     (last_seek_q),
      .prev_valid_i     (prev_valid),
      .prev_gt_i        (prev_gt),
      .prev_track_i     (prev_track),
      .prev_arrival_i   (prev_arrival),
      .prev_id_i        (prev_id),
      .next_valid_i     (next_valid),
      .next_track_i     (next_track),
      .next_arrival_i   (next_arrival),
      .next_id_i        (next_id),
      .nxt_up_found_i   (nxt_up_found),
      .nxt_up_track_i   (nxt_up_track),
      .nxt_up_arrival_i (nxt_up_arrival),
      .nxt_up_id_i      (nxt_up_id),
      .nxt_dn_found_i   (nxt_dn_found),
      .nxt_dn_track_i   (nxt_dn_track),
      .nxt_dn_arrival_i (nxt_dn_arrival),
      .nxt_dn_id_i      (nxt_dn_id),
      .valid_o          (valid_w[i]),
      .gt_o             (gt_w[i]),
      .track_o          (track_w[i]),
      .arrival_o        (arrival_w[i]),
      .id_o             (id_w[i]),
      .up_found_o       (up_found_w[i]),
      .up_track_o       (up_track_w[i]),
      .up_arrival_o     (up_arrival_w[i]),
      .up_id_o          (up_id_w[i]),
      .dn_found_o       (dn_found_w[i]),
      .dn_track_o       (dn_track_w[i]),
      .dn_arrival_o     (dn_arrival_w[i]),
      .dn_id_o          (dn_id_w[i])
    );
  end

endmodule

### hdl/ldrs_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the LOOK disk request scheduler and its bind to the top level.
// Depends on ldrs_pkg and on the top level's ports.
module ldrs_chk import ldrs_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [IdW-1:0]    served_id_i,
  input logic [TrackW-1:0] served_track_i,
  input logic [ArrW-1:0]   served_arrival_i,
  input logic              empty_flag_i,
  input logic              full_flag_i
);

  // A result that is not taken stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(served_id_i) &&
      $stable(served_track_i) && $stable(served_arrival_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(empty_flag_i && full_flag_i))
    else $error("empty and full flagged together");

  // A refused add or an empty get carries no served request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (empty_flag_i || full_flag_i) |->
      served_id_i == '0 && served_track_i == '0 && served_arrival_i == '0)
    else $error("served fields set on a flagged result");

  // One item is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while the previous one is still in work");

endmodule

bind look_disk_request_scheduler ldrs_chk u_ldrs_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .served_id_i      (rsp_o.served_id),
  .served_track_i   (rsp_o.served_track),
  .served_arrival_i (rsp_o.served_arrival),
  .empty_flag_i     (rsp_o.empty_flag),
  .full_flag_i      (rsp_o.full_flag)
);
